// ===== hw/rtl/asp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Archive stream parser package
// Transaction types, parse phase codes and byte role codes.
// ----------------------------------------------------------------------------
package asp_pkg;

  // Parse phase codes; the code above the done phase behaves as done.
  localparam logic [2:0] PhCount = 3'd0;
  localparam logic [2:0] PhPlen  = 3'd1;
  localparam logic [2:0] PhPath  = 3'd2;
  localparam logic [2:0] PhSize  = 3'd3;
  localparam logic [2:0] PhPad   = 3'd4;
  localparam logic [2:0] PhData  = 3'd5;
  localparam logic [2:0] PhDone  = 3'd6;

  // Byte role reported for data bytes and ignored items.
  localparam logic [2:0] RoleData = 3'd5;

  // Field byte counts.
  localparam logic [15:0] CountBytes = 16'd4;
  localparam logic [15:0] PlenBytes  = 16'd2;
  localparam logic [15:0] SizeBytes  = 16'd8;

  // Item op codes.
  localparam logic OpByte = 1'b0;
  localparam logic OpEos  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_in;
  } asp_in_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  byte_out;
    logic        data_valid;
    logic [31:0] file_number;
    logic [15:0] path_length;
    logic [63:0] file_size;
    logic        file_open;
    logic        file_end;
    logic        archive_done;
    logic        truncated;
  } asp_out_t;

endpackage

// ===== hw/rtl/archive_stream_parser.sv =====
`timescale 1ns / 1ps
// Each accepted input's result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one byte per cycle while the skid entry is empty; the per-byte parse update is a single state step.
// Output register plus one skid entry: input keeps flowing while a result waits.
// Input stall rises only when the skid entry is occupied.
// Reset (rst_ni low, asynchronous) returns the parser to the file count phase.
// ----------------------------------------------------------------------------
// Archive stream parser
// Classifies each archive byte (count, path length, path, size, padding,
// data) and tracks file index, decoded lengths and archive completion.
// ----------------------------------------------------------------------------
module archive_stream_parser import asp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  asp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output asp_out_t out_data_o
);

  // Parser state
  logic [2:0]  phase_q, phase_d;
  logic [15:0] collected_q, collected_d;
  logic [15:0] needed_q, needed_d;
  logic [63:0] shift_q, shift_d;
  logic [31:0] files_total_q, files_total_d;
  logic [31:0] position_q, position_d;
  logic [63:0] left_q, left_d;
  logic [1:0]  mod4_q, mod4_d;
  logic [15:0] plen_q, plen_d;
  logic [63:0] fsize_q, fsize_d;

  // Output register and skid entry
  logic     out_valid_q;
  asp_out_t out_q;
  logic     skid_valid_q;
  asp_out_t skid_q;

  logic     accept;
  logic     out_fire;
  asp_out_t res;

  // Next-state scratch
  logic [63:0] shift_acc;
  logic [15:0] coll_inc;
  logic [63:0] left_dec;
  logic [31:0] pos_inc;
  logic [1:0]  pad;
  logic        file_done;
  logic        opened;
  logic [2:0]  role;
  logic        dvalid;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // One parse step for the incoming byte.
  always_comb begin
    phase_d       = phase_q;
    collected_d   = collected_q;
    needed_d      = needed_q;
    shift_d       = shift_q;
    files_total_d = files_total_q;
    position_d    = position_q;
    left_d        = left_q;
    mod4_d        = mod4_q;
    plen_d        = plen_q;
    fsize_d       = fsize_q;
    file_done     = 1'b0;
    opened        = 1'b0;
    role          = RoleData;
    dvalid        = 1'b0;
    coll_inc      = collected_q + 16'd1;
    left_dec      = left_q - 64'd1;
    pos_inc       = position_q + 32'd1;
    pad           = 2'd0 - mod4_q;

    // Merge the byte into the little-endian field accumulator.
    shift_acc = shift_q;
    for (int i = 0; i < 8; i++) begin
      if (collected_q[2:0] == 3'(i)) begin
        shift_acc[8*i +: 8] = shift_q[8*i +: 8] | in_data_i.byte_in;
      end
    end

    if (in_data_i.op == OpByte) begin
      if (phase_q == PhData) begin
        dvalid = 1'b1;
        left_d = left_dec;
        if (left_dec == 64'd0) begin
          file_done = 1'b1;
        end
      end else if (phase_q <= PhPad) begin
        role = phase_q;
        if (phase_q != PhPath) begin
          shift_d = shift_acc;
        end
        collected_d = coll_inc;
        if (coll_inc == needed_q) begin
          // Field complete: clear the accumulator and pick the next phase.
          collected_d = 16'd0;
          shift_d     = 64'd0;
          unique case (phase_q)
            PhCount: begin
              files_total_d = shift_acc[31:0];
              position_d    = 32'd0;
              if (shift_acc[31:0] != 32'd0) begin
                phase_d  = PhPlen;
                needed_d = PlenBytes;
              end else begin
                phase_d  = PhDone;
                needed_d = 16'd0;
              end
            end
            PhPlen: begin
              plen_d = shift_acc[15:0];
              mod4_d = mod4_q + 2'd2;
              if (shift_acc[15:0] != 16'd0) begin
                phase_d  = PhPath;
                needed_d = shift_acc[15:0];
              end else begin
                phase_d  = PhSize;
                needed_d = SizeBytes;
              end
            end
            PhPath: begin
              mod4_d   = mod4_q + plen_q[1:0];
              phase_d  = PhSize;
              needed_d = SizeBytes;
            end
            PhSize: begin
              fsize_d = shift_acc;
              left_d  = shift_acc;
              opened  = 1'b1;
              if (pos_inc == files_total_q && pad != 2'd0) begin
                phase_d  = PhPad;
                needed_d = {14'd0, pad};
              end else if (shift_acc == 64'd0) begin
                file_done = 1'b1;
              end else begin
                phase_d  = PhData;
                needed_d = 16'd0;
              end
            end
            default: begin
              // Padding finished: start data or close an empty file.
              if (left_q == 64'd0) begin
                file_done = 1'b1;
              end else begin
                phase_d  = PhData;
                needed_d = 16'd0;
              end
            end
          endcase
        end
      end
    end

    // Close the current file: advance the index, then done or next header.
    if (file_done) begin
      position_d  = pos_inc;
      collected_d = 16'd0;
      shift_d     = 64'd0;
      if (pos_inc == files_total_q) begin
        phase_d  = PhDone;
        needed_d = 16'd0;
      end else begin
        phase_d  = PhPlen;
        needed_d = PlenBytes;
      end
    end

    res.byte_role    = role;
    res.byte_out     = (in_data_i.op == OpByte) ? in_data_i.byte_in : 8'd0;
    res.data_valid   = dvalid;
    res.file_number  = position_q;
    res.path_length  = plen_d;
    res.file_size    = fsize_d;
    res.file_open    = opened;
    res.file_end     = file_done;
    res.archive_done = (phase_d >= PhDone);
    res.truncated    = (in_data_i.op == OpEos) && (phase_q < PhDone);
  end

  // Advance parser state on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhCount;
      collected_q   <= 16'd0;
      needed_q      <= CountBytes;
      shift_q       <= 64'd0;
      files_total_q <= 32'd0;
      position_q    <= 32'd0;
      left_q        <= 64'd0;
      mod4_q        <= 2'd0;
      plen_q        <= 16'd0;
      fsize_q       <= 64'd0;
    end else if (accept) begin
      phase_q       <= phase_d;
      collected_q   <= collected_d;
      needed_q      <= needed_d;
      shift_q       <= shift_d;
      files_total_q <= files_total_d;
      position_q    <= position_d;
      left_q        <= left_d;
      mod4_q        <= mod4_d;
      plen_q        <= plen_d;
      fsize_q       <= fsize_d;
    end
  end

  // Output register with one skid entry; drain the skid entry first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payloads: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a valid output register");

  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 3'd7)
    else $error("parser reached the unused phase code");

  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (left_q != 64'd0))
    else $error("data phase with no bytes left");

  a_field_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q <= PhPad) |-> (collected_q < needed_q))
    else $error("field byte count overran its length");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q >= PhDone) |=> (phase_q >= PhDone))
    else $error("parser left the done phase");
`endif

endmodule
